/* rtl/ffir_pkg.sv */
// Shared types and constants of the first-fit interval reserver.
package ffir_pkg;

   // Field widths of one request and one result.
   localparam int DAY_W   = 12;
   localparam int TIME_W  = 12;
   localparam int ENTRY_W = DAY_W + 2 * TIME_W;
   localparam int INDEX_W = 2;

   // Width of the resources-in-use register and its value after reset.
   localparam int CSR_W = 3;
   localparam logic [CSR_W-1:0] CSR_RESET = 3'd4;

   // Width used to compare a resource counter against the limits.
   localparam int CMP_W = 5;

   // Default sizes.
   localparam int RESOURCES_DEF = 4;
   localparam int SLOTS_DEF     = 64;

   // One stored reservation.
   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
   } entry_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RES  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

/* rtl/ffir_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ffir_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ffir_match.sv */
// Overlap test of one stored reservation against the pending request.
module ffir_match (
   input  ffir_pkg::entry_type stored,
   input  ffir_pkg::entry_type request,
   output logic                conflict
);

   // Same day and the half-open intervals intersect.
   always_comb begin
      conflict = (stored.day == request.day) &&
                 (stored.start_time < request.end_time) &&
                 (request.start_time < stored.end_time);
   end

endmodule

/* rtl/first_fit_interval_reserver_unit.sv */
// Top level of the first-fit interval reserver: sequencer, fill counts and ports.
//
// A request word on the req_ channel carries a day and a half-open interval
// [start_time, end_time). Resources are checked from index 0 upward; the first
// one with no stored reservation on that day overlapping the request takes it,
// and the rsp_ channel returns granted in tuser and the resource index in tdata.
// A resource that is full, or that lies beyond the resources-in-use register,
// is skipped; with none left the answer is "not granted".
// The block takes one request at a time. The time from one accepted request to
// the next grows with each checked resource and each stored entry read before a
// clash or a grant; a full resource is skipped without a read. The reservation
// memory is read one entry per cycle, and every entry goes through one shared
// overlap comparator.
// The result waits in an output register; a new request is taken while it
// waits, but the next result is held back until the register is free.
// The csr_ channel writes the resources-in-use register; write it only while
// no request is in flight. Reset clears all fill counts at once (no clearing
// pass), sets resources in use to 4 and drops any pending result.
module first_fit_interval_reserver_unit #(
   parameter int RESOURCES          = ffir_pkg::RESOURCES_DEF,
   parameter int SLOTS_PER_RESOURCE = ffir_pkg::SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [39:0]                 req_tdata,  // day, start_time, end_time, zero pad
   // Result channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,  // resource_index, zero pad
   output logic                        rsp_tuser,  // granted
   // Resources-in-use register write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ffir_pkg::CSR_W-1:0]  csr_data
);

   localparam int DEPTH = RESOURCES * SLOTS_PER_RESOURCE;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int RW    = RESOURCES > 1 ? $clog2(RESOURCES) : 1;
   localparam int RCW   = $clog2(RESOURCES + 1);
   localparam int CW    = $clog2(SLOTS_PER_RESOURCE + 1);

   ffir_pkg::state_type                state_ff, state_in;
   ffir_pkg::entry_type                req_ff, req_in;
   logic [RCW-1:0]                     r_ff, r_in;
   logic [AW-1:0]                      base_ff, base_in;
   logic [CW-1:0]                      slot_ff, slot_in;
   logic [CW-1:0]                      fill_ff [RESOURCES];
   logic [CW-1:0]                      fill_in [RESOURCES];
   logic [ffir_pkg::CSR_W-1:0]         csr_ff, csr_in;
   logic                               res_grant_ff, res_grant_in;
   logic [ffir_pkg::INDEX_W-1:0]       res_idx_ff, res_idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_grant_ff, rsp_grant_in;
   logic [ffir_pkg::INDEX_W-1:0]       rsp_idx_ff, rsp_idx_in;

   logic                               req_take;
   logic                               rsp_load;
   logic                               r_done;
   logic                               grant;
   logic                               next_res;
   logic [CW-1:0]                      cur_fill;
   logic                               conflict;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic [ffir_pkg::ENTRY_W-1:0]       rd_data;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;

   // Reservation memory, one region of SLOTS_PER_RESOURCE entries per resource.
   ffir_ram #(
      .WIDTH (ffir_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared overlap comparator.
   ffir_match u_match (
      .stored   (ffir_pkg::entry_type'(rd_data)),
      .request  (req_ff),
      .conflict (conflict)
   );

   assign req_tready = (state_ff == ffir_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Fill count of the resource under test, and end of the resource list.
   assign cur_fill = fill_ff[r_ff[RW-1:0]];
   assign r_done   = (ffir_pkg::CMP_W'(r_ff) >= ffir_pkg::CMP_W'(RESOURCES)) ||
                     (ffir_pkg::CMP_W'(r_ff) >= ffir_pkg::CMP_W'(csr_ff));

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      slot_in      = slot_ff;
      res_grant_in = res_grant_ff;
      res_idx_in   = res_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = base_ff;
      grant        = 1'b0;
      next_res     = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ffir_pkg::ST_IDLE: begin
            if (req_take) begin
               req_in.day        = req_tdata[11:0];
               req_in.start_time = req_tdata[23:12];
               req_in.end_time   = req_tdata[35:24];
               r_in              = '0;
               base_in           = '0;
               state_in          = ffir_pkg::ST_RES;
            end
         end
         ffir_pkg::ST_RES: begin
            if (r_done) begin
               res_grant_in = 1'b0;
               res_idx_in   = '0;
               state_in     = ffir_pkg::ST_DONE;
            end else if (cur_fill == CW'(SLOTS_PER_RESOURCE)) begin
               next_res = 1'b1;
            end else if (cur_fill == '0) begin
               grant = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = base_ff;
               slot_in  = CW'(1);
               state_in = ffir_pkg::ST_SCAN;
            end
         end
         ffir_pkg::ST_SCAN: begin
            // The read data belongs to entry slot_ff - 1.
            if (conflict) begin
               next_res = 1'b1;
               state_in = ffir_pkg::ST_RES;
            end else if (slot_ff == cur_fill) begin
               grant = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(base_ff + AW'(slot_ff));
               slot_in = CW'(slot_ff + 1'b1);
            end
         end
         ffir_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ffir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffir_pkg::ST_IDLE;
         end
      endcase

      // Move on to the next resource.
      if (next_res) begin
         r_in    = RCW'(r_ff + 1'b1);
         base_in = AW'(base_ff + AW'(SLOTS_PER_RESOURCE));
      end

      // Record the reservation in the resource under test.
      if (grant) begin
         res_grant_in = 1'b1;
         res_idx_in   = ffir_pkg::INDEX_W'(r_ff);
         state_in     = ffir_pkg::ST_DONE;
      end
   end

   assign wr_en   = grant;
   assign wr_addr = AW'(base_ff + AW'(cur_fill));

   // Fill counts.
   always_comb begin
      for (int i = 0; i < RESOURCES; i++) begin
         fill_in[i] = fill_ff[i];
      end
      if (grant) begin
         fill_in[r_ff[RW-1:0]] = CW'(cur_fill + 1'b1);
      end
   end

   // Configuration register.
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         csr_in = csr_data;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = res_grant_ff;
         rsp_idx_in   = res_idx_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffir_pkg::ST_IDLE;
         csr_ff       <= ffir_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RESOURCES; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < RESOURCES; i++) begin
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      r_ff         <= r_in;
      base_ff      <= base_in;
      slot_ff      <= slot_in;
      res_grant_ff <= res_grant_in;
      res_idx_ff   <= res_idx_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_grant_ff;
   assign rsp_tdata  = {{(8 - ffir_pkg::INDEX_W){1'b0}}, rsp_idx_ff};

endmodule

/* rtl/ffir_checker.sv */
// Port-level checks of the first-fit interval reserver and their binding.
module ffir_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // A refused request always reports resource index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("not-granted result with nonzero resource index");

   // Once a request word is taken the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a scan was starting");

   // No result survives reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind first_fit_interval_reserver_unit ffir_checker u_ffir_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* dv/testbench.sv */
// Self-checking testbench for the first-fit interval reserver: directed table, then random stages.
`timescale 1ns / 100ps

module testbench;

   localparam int RESOURCES        = ffir_pkg::RESOURCES_DEF;
   localparam int SLOTS            = ffir_pkg::SLOTS_DEF;
   localparam int STAGES           = 8;
   localparam int RANDOM_PER_STAGE = 206;
   localparam int HEAVY_PCT        = 56;
   localparam int LIGHT_PCT        = 7;
   localparam int EMPTY_FROM_PCT   = 96;

   // Resources-in-use value and share of fresh day keys for each random stage.
   localparam int STAGE_IN_USE [STAGES] = '{1, 4, 2, 7, 3, 0, 6, 5};
   localparam int STAGE_FRESH  [STAGES] = '{50, 3, 3, 3, 3, 3, 3, 60};

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic                         granted;
      logic [ffir_pkg::INDEX_W-1:0] index;
   } answer_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [ffir_pkg::DAY_W-1:0]  day;
      logic [ffir_pkg::TIME_W-1:0] start_time;
      logic [ffir_pkg::TIME_W-1:0] end_time;
      logic [ffir_pkg::CSR_W-1:0]  csr_value;
      logic                        typed;
      answer_type                  answer;
   } row_type;

   // Directed part; an answer is typed in only where it is plain, else it is predicted.
   localparam int ROWS = 23;
   row_type plan [ROWS] = '{
      '{ROW_REQ, 12'd0,    12'd0,    12'd4095, 3'd0, 1'b1, '{1'b1, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd100,  12'd200,  3'd0, 1'b1, '{1'b1, 2'd1}},
      '{ROW_REQ, 12'd0,    12'd4094, 12'd4095, 3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd4095, 12'd0,    12'd4095, 3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd200,  12'd300,  3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd500,  12'd500,  3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd4095, 12'd0,    3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd0,    12'd4095, 3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd0,    12'd4095, 3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd0,    12'd4095, 3'd0, 1'b1, '{1'b0, 2'd0}},
      '{ROW_CSR, 12'd0,    12'd0,    12'd0,    3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd1,    12'd0,    12'd10,   3'd0, 1'b1, '{1'b0, 2'd0}},
      '{ROW_CSR, 12'd0,    12'd0,    12'd0,    3'd7, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd1,    12'd0,    12'd10,   3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd0,    12'd0,    12'd1,    3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_CSR, 12'd0,    12'd0,    12'd0,    3'd1, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd1,    12'd5,    12'd20,   3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_CSR, 12'd0,    12'd0,    12'd0,    3'd2, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd1,    12'd5,    12'd20,   3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'd4095, 12'd4095, 12'd4095, 3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'hAAA,  12'h555,  12'hAAA,  3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_REQ, 12'h555,  12'hAAA,  12'h555,  3'd0, 1'b0, '{1'b0, 2'd0}},
      '{ROW_CSR, 12'd0,    12'd0,    12'd0,    3'd4, 1'b0, '{1'b0, 2'd0}}
   };

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [39:0]                  req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [7:0]                   rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [ffir_pkg::CSR_W-1:0]   csr_data   = '0;

   // Predictor state: reservations per resource, fill counts and resources in use.
   ffir_pkg::entry_type          booked [RESOURCES][SLOTS];
   int unsigned                  fill [RESOURCES] = '{default: 0};
   logic [ffir_pkg::CSR_W-1:0]   in_use = ffir_pkg::CSR_RESET;
   answer_type                   awaited [$];
   int                           mismatches = 0;
   int                           sender_idle_pct = 0;
   int                           receiver_stall_pct = 0;
   logic [ffir_pkg::DAY_W-1:0]   last_day = '0;
   logic [ffir_pkg::TIME_W-1:0]  last_end = '0;

   first_fit_interval_reserver_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Books the request in the first resource in use that is not full and has no clash.
   function automatic answer_type reserve_first_fit(
      input logic [ffir_pkg::DAY_W-1:0]  day,
      input logic [ffir_pkg::TIME_W-1:0] start_time,
      input logic [ffir_pkg::TIME_W-1:0] end_time);
      answer_type           ans;
      int unsigned          limit;
      logic                 clash;
      ffir_pkg::entry_type  held;
      ans = '0;
      limit = (in_use > RESOURCES) ? RESOURCES : in_use;
      for (int r = 0; r < limit; r++) begin
         if (fill[r] < SLOTS) begin
            clash = 1'b0;
            for (int i = 0; i < fill[r]; i++) begin
               held = booked[r][i];
               if (held.day == day && held.start_time < end_time && start_time < held.end_time)
                  clash = 1'b1;
            end
            if (!clash) begin
               booked[r][fill[r]] = '{day, start_time, end_time};
               fill[r]++;
               ans.granted = 1'b1;
               ans.index = ffir_pkg::INDEX_W'(r);
               return ans;
            end
         end
      end
      return ans;
   endfunction

   // Offers one request word, idling first at random, and records its answer on acceptance.
   task automatic send_request(input logic [ffir_pkg::DAY_W-1:0] day,
                               input logic [ffir_pkg::TIME_W-1:0] start_time,
                               input logic [ffir_pkg::TIME_W-1:0] end_time, input logic typed,
                               input answer_type answer);
      answer_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, end_time, start_time, day};
      do @(posedge clock); while (!req_tready);
      predicted = reserve_first_fit(day, start_time, end_time);
      awaited.insert(awaited.size(), typed ? answer : predicted);
   endtask

   // Builds a random request: mostly a few busy days, sometimes fresh days or empty intervals.
   task automatic send_random(input int fresh_pct);
      logic [ffir_pkg::DAY_W-1:0]  day;
      logic [ffir_pkg::TIME_W-1:0] s;
      logic [ffir_pkg::TIME_W-1:0] e;
      int                          pick;
      int                          stop;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
         0: begin
            day = '0;
         end
         1: begin
            day = '1;
         end
         2: begin
            day = 12'd1;
         end
         3: begin
            day = 12'h800;
         end
         default: begin
            day = last_day;
         end
      endcase
      if (pick < fresh_pct)
         day = ffir_pkg::DAY_W'($urandom);
      s = ffir_pkg::TIME_W'($urandom);
      if (pick >= EMPTY_FROM_PCT) begin
         e = ffir_pkg::TIME_W'($urandom_range(0, s));
      end else begin
         // Now and then start right where the previous reservation on this day ended.
         if (day == last_day && $urandom_range(0, 3) == 0)
            s = last_end;
         if ($urandom_range(0, 1) != 0)
            stop = int'(s) + $urandom_range(1, 2048);
         else
            stop = int'(s) + $urandom_range(1, 256);
         e = (stop > 4095) ? '1 : ffir_pkg::TIME_W'(stop);
      end
      last_day = day;
      last_end = e;
      send_request(day, s, e, 1'b0, '0);
   endtask

   // Lowers the request valid and waits until every answer has been taken.
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
   endtask

   task automatic write_in_use(input logic [ffir_pkg::CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      in_use = value;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      sender_idle_pct    = (mode == IDLE_SENDER) ? HEAVY_PCT : (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? HEAVY_PCT :
                           (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
   endtask

   // Result checker and random stalls of the result channel.
   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited.size() == 0) begin
            $display("%0t: result with none expected: granted %0b tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            due = awaited.pop_front();
            if (rsp_tuser !== due.granted) begin
               $display("%0t: granted expected %0b actual %0b", $time, due.granted, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata !== {{(8 - ffir_pkg::INDEX_W){1'b0}}, due.index}) begin
               $display("%0t: resource index word expected %0h actual %0h",
                        $time, {{(8 - ffir_pkg::INDEX_W){1'b0}}, due.index}, rsp_tdata);
               mismatches++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Stimulus: reset, directed table, then random stages with changing settings.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idle_mode(IDLE_NONE);
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR) begin
            wait_for_answers();
            write_in_use(plan[k].csr_value);
         end else begin
            send_request(plan[k].day, plan[k].start_time, plan[k].end_time,
                         plan[k].typed, plan[k].answer);
         end
      end
      for (int stage = 0; stage < STAGES; stage++) begin
         wait_for_answers();
         write_in_use(ffir_pkg::CSR_W'(STAGE_IN_USE[stage]));
         set_idle_mode(idle_mode_type'(stage % 4));
         for (int n = 0; n < RANDOM_PER_STAGE; n++) begin
            // Halfway through, hold off until the block has answered everything.
            if (n == RANDOM_PER_STAGE / 2)
               wait_for_answers();
            send_random(STAGE_FRESH[stage]);
         end
      end
      wait_for_answers();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && awaited.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(40_000_000);
      $display("testbench failed");
      $finish;
   end

endmodule
